// ===== hw/rtl/roa_pkg.sv =====
// ----------------------------------------------------------------------------
// roa_pkg
// Types and constants shared by the resource ownership arbiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package roa_pkg;

  // Command codes.
  localparam logic [1:0] CMD_REQUEST    = 2'd0;
  localparam logic [1:0] CMD_REPORT     = 2'd1;
  localparam logic [1:0] CMD_ASSIGN_ALL = 2'd2;

  // Owner code for an unowned resource.
  localparam logic [3:0] OWNER_NONE = 4'd8;

  // Client flag bit positions.
  localparam int FLAG_OPER = 0;
  localparam int FLAG_PEND = 1;

  // Output field geometry.
  localparam int MAX_RESOURCES = 16;
  localparam int MASK_CLIENTS  = 8;

  // Candidate tree for the handover search covers every possible client code.
  localparam int TREE_LEAVES = 16;
  localparam int TREE_DEPTH  = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  client_id;
    logic [31:0] req_tag;
    logic [15:0] resource_mask;
    logic        oper_flag;
  } in_item_t;

  typedef struct packed {
    logic [63:0] owners;
    logic [7:0]  pending_mask;
    logic [7:0]  operational_mask;
    logic        changed;
    logic        accepted;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic exec;
    logic walk_step;
    logic load_out;
  } ctrl_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic need_walk;
    logic walk_last;
  } dp_stat_t;

  // One entry of the handover search.
  typedef struct packed {
    logic        valid;
    logic [3:0]  id;
    logic [31:0] stamp;
  } cand_t;

  // The left operand always holds the lower client number, so it wins ties.
  function automatic cand_t pick_cand(input cand_t a, input cand_t b);
    if (a.valid && (!b.valid || a.stamp >= b.stamp)) begin
      return a;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/roa_ctrl.sv =====
// ----------------------------------------------------------------------------
// roa_ctrl
// Sequencer: accepts a command, runs the resource walk after a deactivation
// and hands the answer to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module roa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output roa_pkg::ctrl_cmd_t      cmd,
  input  wire roa_pkg::dp_stat_t  stat
);
  import roa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.exec      = 1'b0;
    cmd.walk_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = stat.need_walk ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // The previous answer must have left the output register first.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/roa_datapath.sv =====
// ----------------------------------------------------------------------------
// roa_datapath
// Owner table, client records, stamp counter, handover search and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module roa_datapath #(
  parameter int NUM_RESOURCES = 16,
  parameter int NUM_CLIENTS   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire roa_pkg::in_item_t  in_data,
  output roa_pkg::out_item_t      out_data,
  input  wire roa_pkg::ctrl_cmd_t cmd,
  output roa_pkg::dp_stat_t       stat
);
  import roa_pkg::*;

  localparam int RIW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int CIW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int MC  = (NUM_CLIENTS < MASK_CLIENTS) ? NUM_CLIENTS : MASK_CLIENTS;
  localparam logic [3:0]     NC_CODE   = 4'(NUM_CLIENTS);
  localparam logic [RIW-1:0] LAST_RES  = RIW'(NUM_RESOURCES - 1);

  logic [3:0]  owner      [NUM_RESOURCES];
  logic [1:0]  flags      [NUM_CLIENTS];
  logic [15:0] last_mask  [NUM_CLIENTS];
  logic [31:0] last_id    [NUM_CLIENTS];
  logic [31:0] stamp      [NUM_CLIENTS];
  logic [31:0] stamp_count;

  logic [RIW-1:0] rcnt;
  logic [3:0]     walk_client;
  logic           changed;
  logic           accepted;

  logic           cid_ok;
  logic [CIW-1:0] cidx;
  logic           fresh;
  logic [3:0]     winner;
  logic           exec_changed;
  logic           exec_accepted;
  out_item_t      snap;

  cand_t tree [TREE_DEPTH+1][TREE_LEAVES];

  assign cid_ok = (in_data.client_id < NC_CODE) && (in_data.client_id != OWNER_NONE);
  assign cidx   = in_data.client_id[CIW-1:0];
  assign fresh  = cid_ok && (last_id[cidx] <= in_data.req_tag);

  assign stat.need_walk = (in_data.cmd == CMD_REPORT) && fresh && !in_data.oper_flag;
  assign stat.walk_last = (rcnt == LAST_RES);

  // Answer flags of the command being accepted; a walk may still raise changed.
  always_comb begin
    exec_changed  = 1'b0;
    exec_accepted = 1'b0;
    case (in_data.cmd)
      CMD_REQUEST: begin
        exec_changed  = cid_ok;
        exec_accepted = cid_ok;
      end
      CMD_REPORT: begin
        exec_accepted = fresh;
      end
      CMD_ASSIGN_ALL: begin
        exec_changed  = 1'b1;
        exec_accepted = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Best operational claimant of the resource under the walk pointer.
  always_comb begin
    for (int l = 0; l <= TREE_DEPTH; l++) begin
      for (int i = 0; i < TREE_LEAVES; i++) begin
        tree[l][i] = '0;
      end
    end
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      tree[0][k].valid = (4'(k) != OWNER_NONE) && flags[k][FLAG_OPER] && last_mask[k][rcnt];
      tree[0][k].id    = 4'(k);
      tree[0][k].stamp = stamp[k];
    end
    for (int l = 0; l < TREE_DEPTH; l++) begin
      for (int i = 0; i < (TREE_LEAVES >> (l + 1)); i++) begin
        tree[l+1][i] = pick_cand(tree[l][2*i], tree[l][2*i+1]);
      end
    end
    winner = tree[TREE_DEPTH][0].valid ? tree[TREE_DEPTH][0].id : OWNER_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        owner[r] <= OWNER_NONE;
      end
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        flags[c]     <= '0;
        last_mask[c] <= '0;
        last_id[c]   <= '0;
        stamp[c]     <= '0;
      end
      stamp_count <= '0;
      rcnt        <= '0;
      walk_client <= OWNER_NONE;
      changed     <= 1'b0;
      accepted    <= 1'b0;
    end else if (cmd.exec) begin
      rcnt        <= '0;
      walk_client <= in_data.client_id;
      changed     <= exec_changed;
      accepted    <= exec_accepted;
      case (in_data.cmd)
        CMD_REQUEST: begin
          if (cid_ok) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
              if (in_data.resource_mask[r]) begin
                owner[r] <= in_data.client_id;
              end
            end
            flags[cidx][FLAG_PEND] <= 1'b1;
            last_mask[cidx] <= in_data.resource_mask;
            last_id[cidx]   <= in_data.req_tag;
            stamp[cidx]     <= stamp_count;
            stamp_count     <= stamp_count + 32'd1;
          end
        end
        CMD_REPORT: begin
          if (fresh) begin
            if (in_data.oper_flag) begin
              flags[cidx] <= 2'b01;
            end else begin
              flags[cidx] <= 2'b00;
            end
          end
        end
        CMD_ASSIGN_ALL: begin
          for (int r = 0; r < NUM_RESOURCES; r++) begin
            owner[r] <= cid_ok ? in_data.client_id : OWNER_NONE;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.walk_step) begin
      if (owner[rcnt] == walk_client) begin
        owner[rcnt] <= winner;
        changed     <= 1'b1;
      end
      rcnt <= rcnt + RIW'(1);
    end
  end

  // Snapshot of the state once the command has finished.
  always_comb begin
    snap        = '0;
    snap.owners = {MAX_RESOURCES{OWNER_NONE}};
    for (int r = 0; r < NUM_RESOURCES; r++) begin
      snap.owners[4*r +: 4] = owner[r];
    end
    for (int c = 0; c < MC; c++) begin
      snap.pending_mask[c]     = flags[c][FLAG_PEND];
      snap.operational_mask[c] = flags[c][FLAG_OPER];
    end
    snap.changed  = changed;
    snap.accepted = accepted;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= snap;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/resource_ownership_arbiter.sv =====
// ----------------------------------------------------------------------------
// resource_ownership_arbiter
// Keeps one owner per resource and a record per client; answers every
// request, state report or assign-all transaction with the full ownership.
// ----------------------------------------------------------------------------
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    in_data  (roa_pkg::in_item_t)
//   output   out_valid / out_ready  out_data (roa_pkg::out_item_t)
//
// A transaction is executed at the edge it is accepted; its answer is loaded
// into the output register from the done state once that register is free.
// A deactivation first walks the owner table one resource per cycle, all
// clients compared at once in a search tree.
// Reset restores the reset ownership and client records.
// A waiting answer does not block the next acceptance; only the load of the
// following answer waits for out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module resource_ownership_arbiter #(
  parameter int NUM_RESOURCES = 16,
  parameter int NUM_CLIENTS   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire roa_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output roa_pkg::out_item_t      out_data
);
  import roa_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  roa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  roa_datapath #(
    .NUM_RESOURCES (NUM_RESOURCES),
    .NUM_CLIENTS   (NUM_CLIENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire

// ===== bench/tb_resource_ownership_arbiter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_resource_ownership_arbiter
// Self-checking bench for the resource ownership arbiter. A directed table
// walks the reset state, the invalid commands, assign-all at both ends and a
// chain of handovers on deactivation. Random traffic of requests and state
// reports then follows. Every answer is checked field by field against the typed
// answer of its row or an in-bench copy of the ownership table and client
// records. Both handshakes are throttled at random, except in the last random phase.
// ----------------------------------------------------------------------------

module tb_resource_ownership_arbiter;
  import roa_pkg::*;

  localparam int NUM_RESOURCES = 16;
  localparam int NUM_CLIENTS   = 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [63:0] ALL_NONE = {16{OWNER_NONE}};
  localparam int RANDOM_CMDS = 1700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * (NUM_RESOURCES + 2);
  localparam int DIR_ROWS_MAX = 32;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t answer;
  } dir_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Mirror of the block's ownership table and client records.
  logic [3:0]  owner_of [NUM_RESOURCES];
  logic [1:0]  flags_of [NUM_CLIENTS];
  logic [15:0] last_mask_of [NUM_CLIENTS];
  logic [31:0] last_rid_of [NUM_CLIENTS];
  logic [31:0] stamp_of [NUM_CLIENTS];
  logic [31:0] next_stamp;

  out_item_t answers [$];
  dir_row_t  dir_rows [DIR_ROWS_MAX];
  int        n_rows = 0;
  out_item_t want;
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 20;
  int        recv_stall_pct = 73;

  resource_ownership_arbiter #(
    .NUM_RESOURCES(NUM_RESOURCES),
    .NUM_CLIENTS(NUM_CLIENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t command(input logic [1:0] cmd, input logic [3:0] cid,
                                       input logic [31:0] rid, input logic [15:0] mask,
                                       input logic op);
    in_item_t it;
    it.cmd = cmd;
    it.client_id = cid;
    it.req_tag = rid;
    it.resource_mask = mask;
    it.oper_flag = op;
    return it;
  endfunction

  function automatic out_item_t answer(input logic [63:0] owners, input logic [7:0] pend,
                                       input logic [7:0] oper, input logic ch,
                                       input logic acc);
    out_item_t a;
    a.owners = owners;
    a.pending_mask = pend;
    a.operational_mask = oper;
    a.changed = ch;
    a.accepted = acc;
    return a;
  endfunction

  task automatic add_row(input in_item_t it, input logic typed, input out_item_t fixed);
    dir_rows[n_rows] = '{it, typed, fixed};
    n_rows++;
  endtask

  // Executes one command on the mirrored state and returns the full answer.
  function automatic out_item_t apply_command(input in_item_t it);
    out_item_t   a;
    logic [3:0]  c;
    logic [3:0]  best;
    logic [31:0] best_stamp;
    logic        found;
    logic        known;
    a = '0;
    c = it.client_id;
    known = (c < NUM_CLIENTS) && (c != OWNER_NONE);
    if (it.cmd == CMD_REQUEST && known) begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
        if (it.resource_mask[r]) owner_of[r] = c;
      end
      flags_of[c][FLAG_PEND] = 1'b1;
      last_mask_of[c] = it.resource_mask;
      last_rid_of[c] = it.req_tag;
      stamp_of[c] = next_stamp;
      next_stamp = next_stamp + 32'd1;
      a.changed = 1'b1;
      a.accepted = 1'b1;
    end else if (it.cmd == CMD_REPORT && known) begin
      if (last_rid_of[c] <= it.req_tag) begin
        a.accepted = 1'b1;
        flags_of[c] = '0;
        if (it.oper_flag) begin
          flags_of[c][FLAG_OPER] = 1'b1;
        end else begin
          // Each resource of the client goes to the newest operational
          // client that last asked for it; on a stamp tie the lower number wins.
          for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (owner_of[r] == c) begin
              a.changed = 1'b1;
              found = 1'b0;
              best = OWNER_NONE;
              best_stamp = '0;
              for (int k = 0; k < NUM_CLIENTS; k++) begin
                if (flags_of[k][FLAG_OPER] && last_mask_of[k][r] &&
                    (!found || best_stamp < stamp_of[k])) begin
                  found = 1'b1;
                  best = k[3:0];
                  best_stamp = stamp_of[k];
                end
              end
              owner_of[r] = best;
            end
          end
        end
      end
    end else if (it.cmd == CMD_ASSIGN_ALL) begin
      for (int r = 0; r < NUM_RESOURCES; r++) owner_of[r] = known ? c : OWNER_NONE;
      a.changed = 1'b1;
      a.accepted = 1'b1;
    end
    a.owners = ALL_NONE;
    for (int r = 0; r < NUM_RESOURCES; r++) a.owners[4*r +: 4] = owner_of[r];
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      a.pending_mask[k] = flags_of[k][FLAG_PEND];
      a.operational_mask[k] = flags_of[k][FLAG_OPER];
    end
    return a;
  endfunction

  // Mostly well-formed requests and reports, with a share of noise.
  function automatic in_item_t random_command();
    in_item_t    it;
    int          pick;
    logic [3:0]  c;
    logic [15:0] mask;
    logic [31:0] rid;
    pick = $urandom_range(99);
    c = 4'($urandom_range(NUM_CLIENTS - 1));
    case ($urandom_range(3))
      0: mask = 16'($urandom);
      1: mask = 16'h1 << $urandom_range(15);
      2: mask = 16'hFFFF;
      default: mask = 16'($urandom & $urandom);
    endcase
    if (pick < 3) begin
      it = command(CMD_UNUSED, 4'($urandom), $urandom, 16'($urandom), 1'($urandom));
    end else if (pick < 7) begin
      it = command(CMD_ASSIGN_ALL, 4'($urandom), $urandom, mask, 1'($urandom));
    end else if (pick < 12) begin
      it = command(2'($urandom_range(1)), 4'($urandom_range(15, 8)), $urandom, mask,
                   1'($urandom));
    end else if (pick < 52) begin
      it = command(CMD_REQUEST, c, $urandom, mask, 1'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) rid = last_rid_of[c] + 32'($urandom_range(3));
      else if (pick < 85) rid = last_rid_of[c] - 32'd1;
      else rid = $urandom;
      it = command(CMD_REPORT, c, rid, mask, $urandom_range(99) < 55);
    end
    return it;
  endfunction

  task automatic drive_item(input in_item_t it, input logic typed, input out_item_t fixed);
    int        gap;
    out_item_t exp;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp = apply_command(it);
    if (typed) exp = fixed;
    // Newest expectation at the front, oldest taken from the back.
    answers.push_front(exp);
  endtask

  task automatic wait_for_answers();
    while (answers.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (answers.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_data);
        errors++;
      end else begin
        want = answers.pop_back();
        if (out_data.owners !== want.owners) begin
          $display("%0t: owners expected %h actual %h", $time, want.owners, out_data.owners);
          errors++;
        end
        if (out_data.pending_mask !== want.pending_mask) begin
          $display("%0t: pending_mask expected %h actual %h", $time, want.pending_mask,
                   out_data.pending_mask);
          errors++;
        end
        if (out_data.operational_mask !== want.operational_mask) begin
          $display("%0t: operational_mask expected %h actual %h", $time,
                   want.operational_mask, out_data.operational_mask);
          errors++;
        end
        if (out_data.changed !== want.changed) begin
          $display("%0t: changed expected %b actual %b", $time, want.changed,
                   out_data.changed);
          errors++;
        end
        if (out_data.accepted !== want.accepted) begin
          $display("%0t: accepted expected %b actual %b", $time, want.accepted,
                   out_data.accepted);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d transactions outstanding", $time, answers.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < NUM_RESOURCES; r++) owner_of[r] = OWNER_NONE;
    for (int k = 0; k < NUM_CLIENTS; k++) begin
      flags_of[k] = '0;
      last_mask_of[k] = '0;
      last_rid_of[k] = '0;
      stamp_of[k] = '0;
    end
    next_stamp = '0;

    // Rows with a typed answer come first, while the state is still trivial.
    add_row(command(CMD_UNUSED, 4'd0, 32'hFFFFFFFF, 16'hFFFF, 1'b1), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(command(CMD_REQUEST, OWNER_NONE, 32'd1, 16'hFFFF, 1'b0), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(command(CMD_REPORT, 4'd15, 32'hFFFFFFFF, 16'h0, 1'b0), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b0, 1'b0));
    add_row(command(CMD_ASSIGN_ALL, 4'd9, 32'd0, 16'h0, 1'b0), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b1, 1'b1));
    add_row(command(CMD_ASSIGN_ALL, 4'd0, 32'd0, 16'h0, 1'b0), 1'b1,
            answer(64'h0, 8'h00, 8'h00, 1'b1, 1'b1));
    add_row(command(CMD_ASSIGN_ALL, 4'd7, 32'd0, 16'h0, 1'b1), 1'b1,
            answer({16{4'h7}}, 8'h00, 8'h00, 1'b1, 1'b1));
    add_row(command(CMD_ASSIGN_ALL, OWNER_NONE, 32'd0, 16'h0, 1'b0), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b1, 1'b1));
    add_row(command(CMD_REPORT, 4'd0, 32'd0, 16'h0, 1'b1), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h01, 1'b0, 1'b1));
    add_row(command(CMD_REPORT, 4'd0, 32'd0, 16'h0, 1'b0), 1'b1,
            answer(ALL_NONE, 8'h00, 8'h00, 1'b0, 1'b1));
    // Handover chain: three operational clients with overlapping masks, then
    // the owners drop out one by one. One report in between is stale.
    add_row(command(CMD_REQUEST, 4'd0, 32'hFFFFFFFF, 16'hFFFF, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd0, 32'd7, 16'h0, 1'b1), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd0, 32'hFFFFFFFF, 16'h0, 1'b1), 1'b0, '0);
    add_row(command(CMD_REQUEST, 4'd3, 32'd10, 16'h00FF, 1'b1), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd3, 32'd10, 16'h0, 1'b1), 1'b0, '0);
    add_row(command(CMD_REQUEST, 4'd5, 32'd1, 16'h0F0F, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd5, 32'd2, 16'h0, 1'b1), 1'b0, '0);
    add_row(command(CMD_REQUEST, 4'd7, 32'd0, 16'h0000, 1'b0), 1'b0, '0);
    add_row(command(CMD_REQUEST, 4'd7, 32'd100, 16'hFFFF, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd7, 32'd100, 16'h0, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd5, 32'd2, 16'h0, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd0, 32'hFFFFFFFF, 16'h0, 1'b0), 1'b0, '0);
    add_row(command(CMD_REQUEST, 4'd6, 32'd0, 16'h8000, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd1, 32'd0, 16'h0, 1'b0), 1'b0, '0);
    add_row(command(CMD_ASSIGN_ALL, 4'd2, 32'd0, 16'h0, 1'b0), 1'b0, '0);
    add_row(command(CMD_REPORT, 4'd2, 32'd0, 16'h0, 1'b0), 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n_rows; i++) begin
      drive_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].answer);
    end

    // Three throttling phases; the sender holds off until the block drains
    // before each change.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 73;
        recv_stall_pct = 20;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < RANDOM_CMDS / 3; n++) drive_item(random_command(), 1'b0, '0);
      in_valid <= 1'b0;
      @(posedge clk);
      wait_for_answers();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
